// ===== rtl/gif_block_stream_parser_defines.svh =====
// Assertion macros shared by the checker
`ifndef GIF_BLOCK_STREAM_PARSER_DEFINES_SVH
`define GIF_BLOCK_STREAM_PARSER_DEFINES_SVH

// Implication checked outside reset
`define GBSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbsp assertion failed");

// Next-cycle implication checked outside reset
`define GBSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbsp assertion failed");

// Next-cycle implication checked at every edge, reset included
`define GBSP_ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gbsp assertion failed");

`endif

// ===== rtl/gbsp_pkg.sv =====
package gbsp_pkg;

  typedef enum logic [3:0] {
    PH_HDR, PH_LSD, PH_GCT, PH_BLOCK, PH_EXTLABEL, PH_GCE, PH_SKIPLEN,
    PH_SKIPDATA, PH_DESC, PH_LCT, PH_MINCS, PH_DATALEN, PH_DATA, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    K_PALETTE, K_FRAME_CTL, K_CLEAR_RECT, K_IMAGE_START,
    K_DATA, K_IMAGE_END, K_TRAILER, K_ERROR
  } kind_t;

  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  localparam logic [7:0] ERR_SIGNATURE = 8'd1;
  localparam logic [7:0] ERR_NO_TABLE  = 8'd2;
  localparam logic [7:0] ERR_BAD_BLOCK = 8'd3;

  localparam logic [7:0] BYTE_TRAILER   = 8'h3B;
  localparam logic [7:0] BYTE_EXTENSION = 8'h21;
  localparam logic [7:0] BYTE_GCE_LABEL = 8'hF9;
  localparam logic [7:0] BYTE_IMAGE     = 8'h2C;
  localparam logic [2:0] DISPOSE_BG     = 3'd2;
  localparam logic [15:0] DELAY_DEFAULT = 16'd10;
  localparam logic [15:0] DELAY_MIN     = 16'd2;

  typedef struct packed {
    kind_t       kind;
    logic [16:0] pos_left;
    logic [16:0] pos_top;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [23:0] rgb_color;
    logic [7:0]  small_value;
    logic        local_table;
    logic        transparent_on;
    logic [2:0]  disposal_mode;
    logic [15:0] frame_delay;
    logic        last;
  } res_t;

  typedef struct packed {
    phase_t           phase;
    logic [3:0]       byte_count;
    logic [1:0]       tbl_pos;
    logic [7:0]       tbl_idx;
    logic [7:0]       subblock_left;
    logic             global_present;
    logic [2:0]       global_size;
    logic [7:0]       bg_index;
    logic [23:0]      bg_rgb;
    logic [15:0]      rgb_partial;
    logic [2:0]       gce_disposal;
    logic [15:0]      gce_delay;
    logic             gce_transparent;
    logic [7:0]       gce_trans_index;
    logic [3:0][15:0] image_rect;
    logic [3:0]       image_local;
    logic [3:0][15:0] prev_rect;
    logic [2:0]       old_disposal;
  } st_t;

  localparam st_t ST_RESET = '{
    phase: PH_HDR, byte_count: 4'd0, tbl_pos: 2'd0, tbl_idx: 8'd0,
    subblock_left: 8'd0, global_present: 1'b0, global_size: 3'd0,
    bg_index: 8'd0, bg_rgb: 24'd0, rgb_partial: 16'd0, gce_disposal: 3'd0,
    gce_delay: DELAY_DEFAULT, gce_transparent: 1'b0, gce_trans_index: 8'd0,
    image_rect: 64'd0, image_local: 4'd0, prev_rect: 64'd0, old_disposal: 3'd0
  };

endpackage

// ===== rtl/gbsp_if.sv =====
interface gbsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       stream_start;
  modport source (output valid, byte_in, stream_start, input ready);
  modport sink (input valid, byte_in, stream_start, output ready);
endinterface

interface gbsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [16:0] pos_left;
  logic [16:0] pos_top;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [23:0] rgb_color;
  logic [7:0]  small_value;
  logic        local_table;
  logic        transparent_on;
  logic [2:0]  disposal_mode;
  logic [15:0] frame_delay;
  logic        last;
  modport source (output valid, kind, pos_left, pos_top, rect_width, rect_height,
                  rgb_color, small_value, local_table, transparent_on,
                  disposal_mode, frame_delay, last, input ready);
  modport sink (input valid, kind, pos_left, pos_top, rect_width, rect_height,
                rgb_color, small_value, local_table, transparent_on,
                disposal_mode, frame_delay, last, output ready);
endinterface

// ===== rtl/gbsp_front.sv =====
module gbsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          byte_in,
  input  logic                stream_start,
  input  logic [15:0]         origin_x,
  input  logic [15:0]         origin_y,
  output logic [1:0]          push_cnt,
  output gbsp_pkg::res_t      res0,
  output gbsp_pkg::res_t      res1
);

  gbsp_pkg::st_t state_r, state_nxt, cur;
  logic [7:0]  last_idx;
  logic [23:0] rgb_full;
  logic [1:0]  rect_f;
  logic [16:0] img_x, img_y, clr_x, clr_y;

  // Restart parsing on this byte when stream_start is set
  assign cur = stream_start ? gbsp_pkg::ST_RESET : state_r;

  assign rgb_full = {cur.rgb_partial, byte_in};
  assign rect_f   = cur.byte_count[2:1];
  assign img_x = {1'b0, origin_x} + {1'b0, cur.image_rect[0]};
  assign img_y = {1'b0, origin_y} + {1'b0, cur.image_rect[1]};
  assign clr_x = {1'b0, origin_x} + {1'b0, cur.prev_rect[0]};
  assign clr_y = {1'b0, origin_y} + {1'b0, cur.prev_rect[1]};

  // Last entry of the active color table
  always_comb begin
    if (cur.phase == gbsp_pkg::PH_LCT) begin
      last_idx = 8'((9'd2 << cur.image_local[2:0]) - 9'd1);
    end else begin
      last_idx = 8'((9'd2 << cur.global_size) - 9'd1);
    end
  end

  // Next parser state
  always_comb begin
    state_nxt = cur;
    case (cur.phase)
      gbsp_pkg::PH_HDR: begin
        if (!(cur.byte_count == 4'd0 && byte_in != "G") &&
            !(cur.byte_count == 4'd1 && byte_in != "I") &&
            !(cur.byte_count == 4'd2 && byte_in != "F")) begin
          state_nxt.byte_count = cur.byte_count + 4'd1;
          if (cur.byte_count == 4'd5) begin
            state_nxt.byte_count = 4'd0;
            state_nxt.phase = gbsp_pkg::PH_LSD;
          end
        end else begin
          state_nxt.phase = gbsp_pkg::PH_DONE;
        end
      end
      gbsp_pkg::PH_LSD: begin
        if (cur.byte_count == 4'd4) begin
          state_nxt.global_present = byte_in[7];
          state_nxt.global_size = byte_in[2:0];
        end else if (cur.byte_count == 4'd5) begin
          state_nxt.bg_index = byte_in;
        end
        state_nxt.byte_count = cur.byte_count + 4'd1;
        if (cur.byte_count == 4'd6) begin
          state_nxt.byte_count = 4'd0;
          state_nxt.phase = cur.global_present ? gbsp_pkg::PH_GCT : gbsp_pkg::PH_BLOCK;
        end
      end
      gbsp_pkg::PH_GCT, gbsp_pkg::PH_LCT: begin
        case (cur.tbl_pos)
          2'd0: begin
            state_nxt.rgb_partial = {byte_in, 8'h00};
            state_nxt.tbl_pos = 2'd1;
          end
          2'd1: begin
            state_nxt.rgb_partial[7:0] = byte_in;
            state_nxt.tbl_pos = 2'd2;
          end
          default: begin
            if (cur.phase == gbsp_pkg::PH_GCT && cur.tbl_idx == cur.bg_index) begin
              state_nxt.bg_rgb = rgb_full;
            end
            state_nxt.tbl_pos = 2'd0;
            state_nxt.tbl_idx = cur.tbl_idx + 8'd1;
            if (cur.tbl_idx == last_idx) begin
              state_nxt.tbl_idx = 8'd0;
              state_nxt.phase = (cur.phase == gbsp_pkg::PH_GCT) ?
                                gbsp_pkg::PH_BLOCK : gbsp_pkg::PH_MINCS;
            end
          end
        endcase
      end
      gbsp_pkg::PH_BLOCK: begin
        if (byte_in == gbsp_pkg::BYTE_EXTENSION) begin
          state_nxt.phase = gbsp_pkg::PH_EXTLABEL;
        end else if (byte_in == gbsp_pkg::BYTE_IMAGE) begin
          state_nxt.byte_count = 4'd0;
          state_nxt.phase = gbsp_pkg::PH_DESC;
        end else begin
          state_nxt.phase = gbsp_pkg::PH_DONE;
        end
      end
      gbsp_pkg::PH_EXTLABEL: begin
        state_nxt.byte_count = 4'd0;
        state_nxt.phase = (byte_in == gbsp_pkg::BYTE_GCE_LABEL) ?
                          gbsp_pkg::PH_GCE : gbsp_pkg::PH_SKIPLEN;
      end
      gbsp_pkg::PH_GCE: begin
        case (cur.byte_count)
          4'd1: begin
            state_nxt.gce_disposal = byte_in[4:2];
            state_nxt.gce_transparent = byte_in[0];
          end
          4'd2: state_nxt.gce_delay = {8'h00, byte_in};
          4'd3: begin
            state_nxt.gce_delay = {byte_in, cur.gce_delay[7:0]};
            if (byte_in == 8'd0 && cur.gce_delay[7:0] == 8'd0) begin
              state_nxt.gce_delay = gbsp_pkg::DELAY_MIN;
            end
          end
          4'd4: begin
            if (cur.gce_transparent) state_nxt.gce_trans_index = byte_in;
          end
          default: ;
        endcase
        state_nxt.byte_count = cur.byte_count + 4'd1;
        if (cur.byte_count == 4'd5) begin
          state_nxt.byte_count = 4'd0;
          state_nxt.phase = gbsp_pkg::PH_BLOCK;
        end
      end
      gbsp_pkg::PH_SKIPLEN: begin
        if (byte_in == 8'd0) begin
          state_nxt.phase = gbsp_pkg::PH_BLOCK;
        end else begin
          state_nxt.subblock_left = byte_in;
          state_nxt.phase = gbsp_pkg::PH_SKIPDATA;
        end
      end
      gbsp_pkg::PH_SKIPDATA: begin
        state_nxt.subblock_left = cur.subblock_left - 8'd1;
        if (cur.subblock_left == 8'd1) state_nxt.phase = gbsp_pkg::PH_SKIPLEN;
      end
      gbsp_pkg::PH_DESC: begin
        if (cur.byte_count[3] == 1'b0) begin
          if (cur.byte_count[0]) begin
            state_nxt.image_rect[rect_f][15:8] = byte_in;
          end else begin
            state_nxt.image_rect[rect_f][7:0] = byte_in;
          end
          state_nxt.byte_count = cur.byte_count + 4'd1;
        end else begin
          state_nxt.image_local = {byte_in[7], byte_in[2:0]};
          state_nxt.byte_count = 4'd0;
          if (byte_in[7]) begin
            state_nxt.phase = gbsp_pkg::PH_LCT;
          end else if (!cur.global_present) begin
            state_nxt.phase = gbsp_pkg::PH_DONE;
          end else begin
            state_nxt.phase = gbsp_pkg::PH_MINCS;
          end
        end
      end
      gbsp_pkg::PH_MINCS: state_nxt.phase = gbsp_pkg::PH_DATALEN;
      gbsp_pkg::PH_DATALEN: begin
        if (byte_in != 8'd0) begin
          state_nxt.subblock_left = byte_in;
          state_nxt.phase = gbsp_pkg::PH_DATA;
        end else begin
          state_nxt.old_disposal = cur.gce_disposal;
          state_nxt.prev_rect = cur.image_rect;
          state_nxt.gce_disposal = 3'd0;
          state_nxt.gce_transparent = 1'b0;
          state_nxt.gce_delay = gbsp_pkg::DELAY_DEFAULT;
          state_nxt.phase = gbsp_pkg::PH_BLOCK;
        end
      end
      gbsp_pkg::PH_DATA: begin
        state_nxt.subblock_left = cur.subblock_left - 8'd1;
        if (cur.subblock_left == 8'd1) state_nxt.phase = gbsp_pkg::PH_DATALEN;
      end
      default: state_nxt.phase = gbsp_pkg::PH_DONE;
    endcase
  end

  // Result items caused by this byte
  always_comb begin
    res0 = '0;
    res1 = '0;
    push_cnt = 2'd0;
    case (cur.phase)
      gbsp_pkg::PH_HDR: begin
        if ((cur.byte_count == 4'd0 && byte_in != "G") ||
            (cur.byte_count == 4'd1 && byte_in != "I") ||
            (cur.byte_count == 4'd2 && byte_in != "F")) begin
          res0.kind = gbsp_pkg::K_ERROR;
          res0.small_value = gbsp_pkg::ERR_SIGNATURE;
          push_cnt = 2'd1;
        end
      end
      gbsp_pkg::PH_GCT, gbsp_pkg::PH_LCT: begin
        if (cur.tbl_pos == 2'd2) begin
          res0.kind = gbsp_pkg::K_PALETTE;
          res0.rgb_color = rgb_full;
          res0.small_value = cur.tbl_idx;
          res0.local_table = (cur.phase == gbsp_pkg::PH_LCT);
          push_cnt = 2'd1;
        end
      end
      gbsp_pkg::PH_BLOCK: begin
        if (byte_in == gbsp_pkg::BYTE_TRAILER) begin
          res0.kind = gbsp_pkg::K_TRAILER;
          push_cnt = 2'd1;
        end else if (byte_in != gbsp_pkg::BYTE_EXTENSION &&
                     byte_in != gbsp_pkg::BYTE_IMAGE) begin
          res0.kind = gbsp_pkg::K_ERROR;
          res0.small_value = gbsp_pkg::ERR_BAD_BLOCK;
          push_cnt = 2'd1;
        end
      end
      gbsp_pkg::PH_GCE: begin
        if (cur.byte_count == 4'd5) begin
          res0.kind = gbsp_pkg::K_FRAME_CTL;
          res0.transparent_on = cur.gce_transparent;
          res0.disposal_mode = cur.gce_disposal;
          res0.frame_delay = cur.gce_delay;
          res0.small_value = cur.gce_trans_index;
          push_cnt = 2'd1;
        end
      end
      gbsp_pkg::PH_DESC: begin
        if (cur.byte_count[3] && !byte_in[7] && !cur.global_present) begin
          res0.kind = gbsp_pkg::K_ERROR;
          res0.small_value = gbsp_pkg::ERR_NO_TABLE;
          push_cnt = 2'd1;
        end
      end
      gbsp_pkg::PH_MINCS: begin
        res1.kind = gbsp_pkg::K_IMAGE_START;
        res1.pos_left = img_x;
        res1.pos_top = img_y;
        res1.rect_width = cur.image_rect[2];
        res1.rect_height = cur.image_rect[3];
        res1.small_value = byte_in;
        res1.local_table = cur.image_local[3];
        res1.transparent_on = cur.gce_transparent;
        res1.disposal_mode = cur.gce_disposal;
        res1.frame_delay = cur.gce_delay;
        if (cur.old_disposal == gbsp_pkg::DISPOSE_BG) begin
          res0.kind = gbsp_pkg::K_CLEAR_RECT;
          res0.pos_left = clr_x;
          res0.pos_top = clr_y;
          res0.rect_width = cur.prev_rect[2];
          res0.rect_height = cur.prev_rect[3];
          res0.rgb_color = cur.bg_rgb;
          push_cnt = 2'd2;
        end else begin
          res0 = res1;
          res1 = '0;
          push_cnt = 2'd1;
        end
      end
      gbsp_pkg::PH_DATALEN: begin
        if (byte_in == 8'd0) begin
          res0.kind = gbsp_pkg::K_IMAGE_END;
          res0.pos_left = img_x;
          res0.pos_top = img_y;
          res0.rect_width = cur.image_rect[2];
          res0.rect_height = cur.image_rect[3];
          push_cnt = 2'd1;
        end
      end
      gbsp_pkg::PH_DATA: begin
        res0.kind = gbsp_pkg::K_DATA;
        res0.small_value = byte_in;
        push_cnt = 2'd1;
      end
      default: ;
    endcase
    // Mark the final item of this byte
    if (push_cnt == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
    if (!accept) push_cnt = 2'd0;
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbsp_pkg::ST_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/gbsp_queue.sv =====
module gbsp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  gbsp_pkg::res_t wdata0,
  input  gbsp_pkg::res_t wdata1,
  input  logic           pop,
  output logic           space_ok,
  output logic           not_empty,
  output gbsp_pkg::res_t rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  gbsp_pkg::res_t mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt, wptr_p1;
  logic [CW-1:0] count_r, count_nxt;

  assign wptr_p1   = wptr_r + AW'(1);
  assign space_ok  = (count_r <= CW'(DEPTH - 2));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rptr_r];

  // Move pointers and fill level
  always_comb begin
    wptr_nxt  = wptr_r + AW'(push_cnt);
    rptr_nxt  = rptr_r + AW'(pop);
    count_nxt = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Store up to two items a cycle
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wptr_r] <= wdata0;
    if (push_cnt == 2'd2) mem_r[wptr_p1] <= wdata1;
  end

endmodule

// ===== rtl/gbsp_back.sv =====
module gbsp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  gbsp_pkg::res_t q_data,
  output logic           q_pop,
  gbsp_out_if.source     out_ch
);

  logic           valid_r, valid_nxt;
  gbsp_pkg::res_t data_r;

  // Load the output register from the queue when it is empty or being drained
  assign q_pop     = q_not_empty && (!valid_r || out_ch.ready);
  assign valid_nxt = q_pop || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= q_data;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = data_r.kind;
  assign out_ch.pos_left       = data_r.pos_left;
  assign out_ch.pos_top        = data_r.pos_top;
  assign out_ch.rect_width     = data_r.rect_width;
  assign out_ch.rect_height    = data_r.rect_height;
  assign out_ch.rgb_color      = data_r.rgb_color;
  assign out_ch.small_value    = data_r.small_value;
  assign out_ch.local_table    = data_r.local_table;
  assign out_ch.transparent_on = data_r.transparent_on;
  assign out_ch.disposal_mode  = data_r.disposal_mode;
  assign out_ch.frame_delay    = data_r.frame_delay;
  assign out_ch.last           = data_r.last;

endmodule

// ===== rtl/gif_block_stream_parser.sv =====
// Bytes pass the parser, the result queue (QUEUE_DEPTH entries) and the output
// register to out_ch. The parser takes one byte per cycle while the queue has room
// for two items; results leave at one per cycle while out_ch.ready is high. An
// image-start byte that also yields a clear rectangle pushes both into the queue.
// Reset (rst_n low, synchronous): parser to header phase, queue and output empty,
// origin registers to 0.
module gif_block_stream_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  gbsp_in_if.sink     in_ch,
  gbsp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]    origin_x_r, origin_y_r;
  logic           accept, space_ok, q_not_empty, q_pop;
  logic [1:0]     push_cnt;
  gbsp_pkg::res_t res0, res1, q_data;

  // Hold origin registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gbsp_pkg::CFG_ORIGIN_X) origin_x_r <= cfg_wdata;
      if (cfg_index == gbsp_pkg::CFG_ORIGIN_Y) origin_y_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;

  gbsp_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .byte_in(in_ch.byte_in),
    .stream_start(in_ch.stream_start), .origin_x(origin_x_r),
    .origin_y(origin_y_r), .push_cnt(push_cnt), .res0(res0), .res1(res1)
  );

  gbsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push_cnt(push_cnt), .wdata0(res0),
    .wdata1(res1), .pop(q_pop), .space_ok(space_ok),
    .not_empty(q_not_empty), .rdata(q_data)
  );

  gbsp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_not_empty(q_not_empty), .q_data(q_data),
    .q_pop(q_pop), .out_ch(out_ch)
  );

endmodule

// ===== rtl/gbsp_checker.sv =====
`include "gif_block_stream_parser_defines.svh"

module gbsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic       out_last
);

  // Output register empties on reset
  `GBSP_ASSERT_NXT_ALL(a_reset_empty, !rst_n, !out_valid)
  // Stalled result holds
  `GBSP_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_kind))
  // Trailer and error always close their byte
  `GBSP_ASSERT_IMP(a_stop_last, out_valid && (out_kind == gbsp_pkg::K_TRAILER || out_kind == gbsp_pkg::K_ERROR), out_last)
  // Clear rectangle is always followed by image start
  `GBSP_ASSERT_IMP(a_clear_not_last, out_valid && out_kind == gbsp_pkg::K_CLEAR_RECT, !out_last)

endmodule

bind gif_block_stream_parser gbsp_checker u_gbsp_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.kind), .out_last(out_ch.last)
);
